// File: design/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned COUNT_W  = 11;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY      = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_word;
    logic                     pop_failed;
    logic                     push_dropped;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // item taken this cycle
    logic fill;    // read data for the pending pop is on the RAM output
  } deq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_read;  // presented item is a pop that must refetch an end word
  } deq_stat_t;

endpackage

// File: design/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  deq_pkg::deq_stat_t stat_i,
  output deq_pkg::deq_cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, take, load;

  // new item only when nothing is pending and the result slot is free or draining
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign take       = out_valid_q && !out_stall_i;
  assign load       = (accept && !stat_i.needs_read) || (state_q == ST_FILL);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && stat_i.needs_read) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = load ? 1'b1 : (take ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = accept;
  assign cmd_o.fill   = (state_q == ST_FILL);

endmodule

// File: design/deq_datapath.sv
`timescale 1ns / 1ps

module deq_datapath #(
  parameter int unsigned CAPACITY = deq_pkg::CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  deq_pkg::in_item_t   in_item_i,
  input  deq_pkg::deq_cmd_t   cmd_i,
  output deq_pkg::deq_stat_t  stat_o,
  output deq_pkg::out_item_t  out_item_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam int unsigned ExtW = (CntW > deq_pkg::COUNT_W) ? CntW : deq_pkg::COUNT_W;
  localparam int unsigned WW   = deq_pkg::WORD_W;

  // sum is below twice the capacity, so one conditional subtract wraps it
  function automatic logic [IdxW-1:0] wrap_idx(input logic [SumW-1:0] s);
    logic [SumW-1:0] r;
    r = (s >= SumW'(CAPACITY)) ? (s - SumW'(CAPACITY)) : s;
    return r[IdxW-1:0];
  endfunction

  logic [IdxW-1:0]        fi_q, fi_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [WW-1:0]   front_q, front_d, back_q, back_d;
  logic                   refill_back_q, refill_back_d;
  deq_pkg::out_item_t     res_q, res_d;

  logic                   full, empty;
  logic                   wr, rd;
  logic [IdxW-1:0]        waddr, raddr;
  logic signed [WW-1:0]   popped;
  logic                   pop_failed, push_dropped, needs_read;
  logic [ExtW-1:0]        cnt_wide;
  logic [WW-1:0]          rdata;

  assign full  = (cnt_q == CntW'(CAPACITY));
  assign empty = (cnt_q == '0);

  always_comb begin
    fi_d          = fi_q;
    cnt_d         = cnt_q;
    front_d       = front_q;
    back_d        = back_q;
    wr            = 1'b0;
    waddr         = fi_q;
    rd            = 1'b0;
    raddr         = fi_q;
    popped        = '0;
    pop_failed    = 1'b0;
    push_dropped  = 1'b0;
    needs_read    = 1'b0;
    refill_back_d = 1'b0;
    case (in_item_i.command)
      deq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          push_dropped = 1'b1;
        end else begin
          fi_d    = (fi_q == '0) ? IdxW'(CAPACITY - 1) : (fi_q - IdxW'(1));
          wr      = 1'b1;
          waddr   = fi_d;
          cnt_d   = cnt_q + CntW'(1);
          front_d = in_item_i.data_in;
          if (empty) begin
            back_d = in_item_i.data_in;
          end
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          push_dropped = 1'b1;
        end else begin
          wr     = 1'b1;
          waddr  = wrap_idx(SumW'(fi_q) + SumW'(cnt_q));
          cnt_d  = cnt_q + CntW'(1);
          back_d = in_item_i.data_in;
          if (empty) begin
            front_d = in_item_i.data_in;
          end
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          popped     = deq_pkg::EMPTY_WORD;
          pop_failed = 1'b1;
        end else begin
          popped     = front_q;
          fi_d       = wrap_idx(SumW'(fi_q) + SumW'(1));
          cnt_d      = cnt_q - CntW'(1);
          needs_read = (cnt_d != '0);
          rd         = needs_read;
          raddr      = fi_d;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          popped     = deq_pkg::EMPTY_WORD;
          pop_failed = 1'b1;
        end else begin
          popped        = back_q;
          cnt_d         = cnt_q - CntW'(1);
          needs_read    = (cnt_d != '0);
          rd            = needs_read;
          raddr         = wrap_idx(SumW'(fi_q) + SumW'(cnt_q) - SumW'(2));
          refill_back_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    cnt_wide           = ExtW'(cnt_d);
    res_d.popped_word  = popped;
    res_d.pop_failed   = pop_failed;
    res_d.push_dropped = push_dropped;
    res_d.entry_count  = cnt_wide[deq_pkg::COUNT_W-1:0];
    res_d.is_empty     = (cnt_d == '0);
    res_d.front_word   = (cnt_d == '0) ? deq_pkg::EMPTY_WORD : front_d;
    res_d.back_word    = (cnt_d == '0) ? deq_pkg::EMPTY_WORD : back_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accept) begin
      fi_q  <= fi_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      front_q       <= front_d;
      back_q        <= back_d;
      refill_back_q <= refill_back_d;
      res_q         <= res_d;
    end else if (cmd_i.fill) begin
      if (refill_back_q) begin
        back_q          <= rdata;
        res_q.back_word <= rdata;
      end else begin
        front_q          <= rdata;
        res_q.front_word <= rdata;
      end
    end
  end

  deq_ram #(
    .Width(WW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr && cmd_i.accept),
    .waddr_i(waddr),
    .wdata_i(in_item_i.data_in),
    .re_i   (rd && cmd_i.accept),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign stat_o.needs_read = needs_read;
  assign out_item_o        = res_q;

endmodule

// File: design/double_ended_queue.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake                Payload
// in       in   in_valid_i / in_stall_o  in_item_i  (command, data_in)
// out      out  out_valid_o / out_stall_i out_item_o (popped word, flags, count, ends)
//
// Pushes, queries, failed pops and pops that empty the queue need no refetch;
// pops that leave words behind stall the input until the registered RAM read
// has refetched the new front or back word.
// Reset leaves the queue empty; the word store itself is not cleared.
// A result waiting under out_stall_i holds its register and stalls the input.
module double_ended_queue #(
  parameter int unsigned CAPACITY = deq_pkg::CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  deq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output deq_pkg::out_item_t out_item_o
);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;

  // sequencing: idle / waiting for refetch, plus result-valid flag
  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // ring buffer, front index, count, cached end words and result register
  deq_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_item_o(out_item_o)
  );

  // after an item goes in, either its result is up or a refetch is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (out_valid_o || in_stall_o))
  else $error("accepted item produced neither result nor pending refetch");

  // a failed pop reports the all-ones word and never a dropped push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.pop_failed) |->
      ((out_item_o.popped_word == deq_pkg::EMPTY_WORD) && !out_item_o.push_dropped))
  else $error("failed pop result malformed");

  // an empty queue reports both ends as all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.is_empty) |->
      ((out_item_o.front_word == deq_pkg::EMPTY_WORD) &&
       (out_item_o.back_word == deq_pkg::EMPTY_WORD)))
  else $error("empty queue reports end words");

endmodule
